[design/b32dec_pkg.sv]
// Shared types, constants and the alphabet decode for the base32 frame decoder.
package b32dec_pkg;

    localparam int CHAR_W  = 8;
    localparam int EXP_W   = 12;
    localparam int ACC_W   = 12;
    localparam int PEND_W  = 4;
    localparam int SYM_W   = 5;
    localparam int BYTE_W  = 8;

    localparam logic [EXP_W-1:0]  EXP_RESET  = 12'd423;
    localparam logic [PEND_W-1:0] SYM_BITS   = 4'd5;
    localparam logic [PEND_W-1:0] BYTE_BITS  = 4'd8;
    localparam logic [CHAR_W-1:0] CH_A       = 8'h41;
    localparam logic [CHAR_W-1:0] CH_Z       = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_2       = 8'h32;
    localparam logic [CHAR_W-1:0] CH_7       = 8'h37;
    localparam logic [SYM_W-1:0]  DIGIT_BASE = 5'd26;

    // Decoded character: symbol value and an out-of-alphabet flag
    typedef struct packed {
        logic             bad;
        logic [SYM_W-1:0] value;
    } sym_t;

    // Map an ASCII character to its 5-bit base32 value
    function automatic sym_t sym_decode(input logic [CHAR_W-1:0] ch);
        sym_t        s;
        logic [CHAR_W-1:0] off;
        s   = '{bad: 1'b1, value: '0};
        off = '0;
        if (ch >= CH_A && ch <= CH_Z)
        begin
            off     = ch - CH_A;
            s.bad   = 1'b0;
            s.value = off[SYM_W-1:0];
        end
        else if (ch >= CH_2 && ch <= CH_7)
        begin
            off     = ch - CH_2;
            s.bad   = 1'b0;
            s.value = DIGIT_BASE + off[SYM_W-1:0];
        end
        return s;
    endfunction

endpackage

[design/base32_strict_fixed_length_decoder_top.sv]
// Top level of the strict fixed-length base32 frame decoder.
// Usage:
//   Slave stream (s_*) takes one uppercase base32 character per transfer;
//   s_tlast marks the final character of a frame.
//   Master stream (m_*) gives at most one result per character: a decoded
//   byte when eight bits complete and the frame has not failed, and/or the
//   frame status on the result of the last character (m_tlast). Characters
//   that complete no byte and are not last produce no transfer.
//   Configuration channel (cfg_*) writes expected_bytes; it is always ready
//   and must only be written while the decoder is idle.
// Timing:
//   The result of an accepted character is in the output register in the next
//   cycle. One character is taken every cycle while s_tready is high; the decode,
//   shift and counter update sit in one combinational pass before that register.
// Stall:
//   While a result waits in the output register and m_tready is low,
//   s_tready is low; the input is taken again in the cycle m_tready rises.
// Reset:
//   rst_n clears the frame state, empties the output register and restores
//   expected_bytes to 423.
module base32_strict_fixed_length_decoder_top #(
    parameter int MAX_FRAME_BYTES = 4095
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // configuration write
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [b32dec_pkg::EXP_W-1:0]     cfg_data,   // expected_bytes
    // character stream in
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [b32dec_pkg::CHAR_W-1:0]    s_tdata,    // [7:0] char_in
    input  logic                             s_tlast,    // last_char
    // result stream out
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [b32dec_pkg::BYTE_W-1:0]    m_tdata,    // [7:0] data_byte
    output logic [1:0]                       m_tuser,    // [0] byte_valid, [1] frame_status
    output logic                             m_tlast     // frame_end
);
    import b32dec_pkg::*;

    localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 1);
    localparam int CMP_W = (CNT_W > EXP_W) ? CNT_W : EXP_W;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_FRAME_BYTES);

    // state
    logic [EXP_W-1:0]  exp_reg;
    logic [ACC_W-1:0]  acc_reg,    acc_next;
    logic [PEND_W-1:0] pend_reg,   pend_next;
    logic [CNT_W-1:0]  cnt_reg,    cnt_next;
    logic              failed_reg, failed_next;

    // output register
    logic              mvalid_reg,  mvalid_next;
    logic [BYTE_W-1:0] mdata_reg,   mdata_next;
    logic              mbyte_reg,   mbyte_next;
    logic              mstatus_reg, mstatus_next;
    logic              mlast_reg,   mlast_next;

    logic              s_fire;
    sym_t              sym;
    logic [ACC_W-1:0]  acc_shift;
    logic [PEND_W-1:0] pend_sum;
    logic [PEND_W-1:0] pend_rem;
    logic              have_byte;
    logic [BYTE_W-1:0] byte_val;
    logic [CMP_W-1:0]  cnt_ext;
    logic [CMP_W-1:0]  exp_ext;
    logic [SYM_W-1:0]  spare_mask;
    logic              end_fail;

    assign cfg_ready = 1'b1;
    assign s_tready  = !mvalid_reg || m_tready;
    assign s_fire    = s_tvalid && s_tready;

    assign sym       = sym_decode(s_tdata);
    assign acc_shift = {acc_reg[ACC_W-SYM_W-1:0], sym.value};
    assign pend_sum  = pend_reg + SYM_BITS;
    assign pend_rem  = pend_sum - BYTE_BITS;
    assign cnt_ext   = CMP_W'(cnt_reg);
    assign exp_ext   = CMP_W'(exp_reg);

    // Decode one character and advance the frame state
    always_comb
    begin
        acc_next    = acc_reg;
        pend_next   = pend_reg;
        cnt_next    = cnt_reg;
        failed_next = failed_reg;
        have_byte   = 1'b0;
        byte_val    = '0;
        spare_mask  = '0;
        end_fail    = 1'b0;
        if (!failed_reg)
        begin
            if (sym.bad)
            begin
                failed_next = 1'b1;
            end
            else
            begin
                acc_next  = acc_shift;
                pend_next = pend_sum;
                if (pend_sum >= BYTE_BITS)
                begin
                    pend_next = pend_rem;
                    if (cnt_ext >= exp_ext || cnt_reg >= CNT_MAX)
                    begin
                        failed_next = 1'b1;
                    end
                    else
                    begin
                        byte_val  = acc_shift[pend_rem +: BYTE_W];
                        have_byte = 1'b1;
                        cnt_next  = cnt_reg + 1'b1;
                    end
                end
            end
        end
        // End-of-frame checks on the updated state
        spare_mask = SYM_W'((6'd1 << pend_next) - 6'd1);
        if (pend_next >= SYM_BITS)
            end_fail = 1'b1;
        else if ((acc_next[SYM_W-1:0] & spare_mask) != '0)
            end_fail = 1'b1;
        if (CMP_W'(cnt_next) != exp_ext)
            end_fail = 1'b1;
    end

    // Form the result; the register block clears the frame after its last character
    always_comb
    begin
        mvalid_next  = mvalid_reg && !m_tready;
        mdata_next   = mdata_reg;
        mbyte_next   = mbyte_reg;
        mstatus_next = mstatus_reg;
        mlast_next   = mlast_reg;
        if (s_fire && (have_byte || s_tlast))
        begin
            mvalid_next  = 1'b1;
            mdata_next   = byte_val;
            mbyte_next   = have_byte;
            mlast_next   = s_tlast;
            mstatus_next = s_tlast && (failed_next || end_fail);
        end
    end

    // Hold the configuration and frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_reg    <= EXP_RESET;
            acc_reg    <= '0;
            pend_reg   <= '0;
            cnt_reg    <= '0;
            failed_reg <= 1'b0;
            mvalid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                exp_reg <= cfg_data;
            if (s_fire)
            begin
                if (s_tlast)
                begin
                    acc_reg    <= '0;
                    pend_reg   <= '0;
                    cnt_reg    <= '0;
                    failed_reg <= 1'b0;
                end
                else
                begin
                    acc_reg    <= acc_next;
                    pend_reg   <= pend_next;
                    cnt_reg    <= cnt_next;
                    failed_reg <= failed_next;
                end
            end
            mvalid_reg <= mvalid_next;
        end
    end

    // Result payload, no reset needed
    always_ff @(posedge clk)
    begin
        mdata_reg   <= mdata_next;
        mbyte_reg   <= mbyte_next;
        mstatus_reg <= mstatus_next;
        mlast_reg   <= mlast_next;
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;
    assign m_tuser  = {mstatus_reg, mbyte_reg};
    assign m_tlast  = mlast_reg;

`ifndef SYNTHESIS
    // A shown result always carries a byte or a frame end
    a_result_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (mbyte_reg || mlast_reg))
        else $error("result with neither byte nor frame end");

    // Status is only reported on the frame end
    a_status_on_end: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && mstatus_reg) |-> mlast_reg)
        else $error("frame status outside frame end");

    // Frame state is cleared after the last character
    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (s_fire && s_tlast) |=> (cnt_reg == '0 && pend_reg == '0 && !failed_reg))
        else $error("frame state not cleared after last character");

    // Leftover bit count never reaches a whole byte
    a_pend_range: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg < BYTE_BITS)
        else $error("pending bit count out of range");
`endif

endmodule

[sim/tb_top.sv]
// Self-checking testbench for the strict fixed-length base32 frame decoder.
`timescale 1ns / 100ps

// Decoded-result scoreboard: tracks the frame state and queues expected results
class decode_scoreboard;

    typedef struct packed {
        logic [7:0] data;
        logic       byte_ok;
        logic       frame_end;
        logic       refused;
    } decoded_t;

    logic [11:0] expected_len;
    logic [11:0] acc;
    logic [3:0]  pend;
    logic [11:0] emitted;
    logic        failed;
    int          max_bytes;
    int          errors;
    decoded_t    decoded_due[$];

    function new(input int max_frame_bytes);
        max_bytes    = max_frame_bytes;
        expected_len = b32dec_pkg::EXP_RESET;
        acc          = '0;
        pend         = '0;
        emitted      = '0;
        failed       = 1'b0;
        errors       = 0;
    endfunction

    function void set_expected(input logic [11:0] len);
        expected_len = len;
    endfunction

    // Advance the frame state by one accepted character; return 0 if it was ignored
    function bit decode_char(input logic [7:0] ch, input logic last);
        logic [4:0]  sym;
        logic [7:0]  off;
        logic        sym_ok;
        logic        got;
        logic [7:0]  byte_val;
        logic [11:0] shifted;
        logic [11:0] spare_mask;
        decoded_t    r;
        bit          used;
        used     = !failed || last;
        got      = 1'b0;
        byte_val = '0;
        sym      = '0;
        sym_ok   = 1'b0;
        if (!failed)
        begin
            if (ch >= b32dec_pkg::CH_A && ch <= b32dec_pkg::CH_Z)
            begin
                off    = ch - b32dec_pkg::CH_A;
                sym    = off[4:0];
                sym_ok = 1'b1;
            end
            else if (ch >= b32dec_pkg::CH_2 && ch <= b32dec_pkg::CH_7)
            begin
                off    = ch - b32dec_pkg::CH_2;
                sym    = off[4:0] + b32dec_pkg::DIGIT_BASE;
                sym_ok = 1'b1;
            end
            if (!sym_ok)
                failed = 1'b1;
            else
            begin
                acc  = {acc[6:0], sym};
                pend = pend + 4'd5;
                if (pend >= 4'd8)
                begin
                    pend = pend - 4'd8;
                    if (emitted >= expected_len || emitted >= max_bytes)
                        failed = 1'b1;
                    else
                    begin
                        shifted  = acc >> pend;
                        byte_val = shifted[7:0];
                        got      = 1'b1;
                        emitted  = emitted + 12'd1;
                    end
                end
            end
        end
        if (got || last)
        begin
            r.data      = byte_val;
            r.byte_ok   = got;
            r.frame_end = last;
            r.refused   = 1'b0;
            if (last)
            begin
                // End-of-frame checks: leftover bits, spare bits, byte count
                spare_mask = (12'd1 << pend) - 12'd1;
                if (pend >= 4'd5)
                    failed = 1'b1;
                else if (pend != 4'd0 && (acc & spare_mask) != 12'd0)
                    failed = 1'b1;
                if (emitted != expected_len)
                    failed = 1'b1;
                r.refused = failed;
                acc       = '0;
                pend      = '0;
                emitted   = '0;
                failed    = 1'b0;
            end
            decoded_due.push_back(r);
        end
        return used;
    endfunction

    // Compare one output transfer with the oldest expected result
    function void check_decoded(input logic [7:0] data, input logic [1:0] user,
                                input logic last);
        decoded_t want;
        if (decoded_due.size() == 0)
        begin
            errors++;
            if (errors <= 10)
                $display("unexpected result: data=%h byte_valid=%b status=%b last=%b",
                         data, user[0], user[1], last);
            return;
        end
        want = decoded_due.pop_front();
        if (data !== want.data || user[0] !== want.byte_ok ||
            last !== want.frame_end || user[1] !== want.refused)
        begin
            errors++;
            if (errors <= 10)
                $display("mismatch: exp data=%h bv=%b end=%b st=%b, got data=%h bv=%b end=%b st=%b",
                         want.data, want.byte_ok, want.frame_end, want.refused,
                         data, user[0], last, user[1]);
        end
    endfunction

endclass

module tb_top;

    import b32dec_pkg::*;

    localparam int MAX_BYTES   = 4095;
    localparam int CYCLE_LIMIT = 300000;

    typedef enum int {
        FR_CLEAN,
        FR_DIRTY_SPARE,
        FR_OVERRUN,
        FR_TRUNCATED,
        FR_BAD_CHAR,
        FR_NOISE
    } frame_kind_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [EXP_W-1:0]   cfg_data;
    logic               s_tvalid;
    logic               s_tready;
    logic [CHAR_W-1:0]  s_tdata;
    logic               s_tlast;
    logic               m_tvalid;
    logic               m_tready;
    logic [BYTE_W-1:0]  m_tdata;
    logic [1:0]         m_tuser;
    logic               m_tlast;

    decode_scoreboard   sb;
    int                 send_idle_pct;
    int                 recv_idle_pct;
    int                 live_chars;
    int                 cycles;
    logic [11:0]        cur_expected;

    base32_strict_fixed_length_decoder_top #(
        .MAX_FRAME_BYTES (MAX_BYTES)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // Free-running clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Random back-pressure on the result stream
    always @(posedge clk)
        if (rst_n)
            m_tready <= ($urandom_range(99, 0) >= recv_idle_pct);

    // Observe transfers on both streams
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            if (sb.decode_char(s_tdata, s_tlast))
                live_chars <= live_chars + 1;
        if (rst_n && m_tvalid && m_tready)
            sb.check_decoded(m_tdata, m_tuser, m_tlast);
    end

    function automatic logic [7:0] b32_char(input logic [4:0] v);
        if (v < DIGIT_BASE)
            return CH_A + v;
        return CH_2 + (v - DIGIT_BASE);
    endfunction

    // Offer one character, with a random gap first, and hold until it is taken
    task automatic send_char(input logic [7:0] ch, input logic last);
        while ($urandom_range(99, 0) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        s_tlast  <= last;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic send_text(input string txt);
        for (int i = 0; i < txt.len(); i++)
            send_char(txt[i], i == txt.len() - 1);
    endtask

    // Stop sending, let the last transfer reach the scoreboard, drain the results
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.decoded_due.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_expected(input logic [11:0] len);
        cfg_valid <= 1'b1;
        cfg_data  <= len;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.set_expected(len);
        cur_expected = len;
    endtask

    // Encode random bytes as a base32 body, optionally damage it, then send it
    task automatic send_frame(input frame_kind_t kind, input int n_bytes);
        bit          stream[$];
        logic [7:0]  text[$];
        logic [7:0]  b;
        logic [7:0]  c;
        logic [4:0]  sym;
        int          pad;
        int          pos;
        for (int i = 0; i < n_bytes; i++)
        begin
            b = 8'($urandom_range(255, 0));
            for (int k = 7; k >= 0; k--)
                stream.push_back(b[k]);
        end
        pad = 0;
        while (stream.size() % 5 != 0)
        begin
            stream.push_back(1'b0);
            pad++;
        end
        if (kind == FR_DIRTY_SPARE && pad > 0)
            stream[stream.size() - 1 - $urandom_range(pad - 1, 0)] = 1'b1;
        for (int i = 0; i < stream.size(); i += 5)
        begin
            for (int k = 0; k < 5; k++)
                sym = {sym[3:0], stream[i + k]};
            text.push_back(b32_char(sym));
        end
        case (kind)
            FR_OVERRUN:
                repeat ($urandom_range(3, 1))
                    text.push_back(b32_char(5'($urandom_range(31, 0))));
            FR_TRUNCATED:
                repeat ($urandom_range(3, 1))
                    if (text.size() > 1)
                        void'(text.pop_back());
            FR_BAD_CHAR:
            begin
                do
                    c = 8'($urandom_range(255, 0));
                while ((c >= CH_A && c <= CH_Z) || (c >= CH_2 && c <= CH_7));
                pos = $urandom_range(text.size() - 1, 0);
                text[pos] = c;
            end
            FR_NOISE:
            begin
                text.delete();
                repeat ($urandom_range(12, 1))
                    if ($urandom_range(1, 0) != 0)
                        text.push_back(b32_char(5'($urandom_range(31, 0))));
                    else
                        text.push_back(8'($urandom_range(255, 0)));
            end
            default: ;
        endcase
        for (int i = 0; i < text.size(); i++)
            send_char(text[i], i == text.size() - 1);
    endtask

    // One idling mix: several config settings, each with a handful of frames
    task automatic run_phase(input int send_pct, input int recv_pct, input int goal);
        int          start;
        int          r;
        logic [11:0] len;
        frame_kind_t kind;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        start = live_chars;
        while (live_chars - start < goal)
        begin
            wait_idle();
            r = $urandom_range(9, 0);
            if (r == 0)
                len = 12'd0;
            else if (r == 1)
                len = 12'($urandom_range(40, 13));
            else
                len = 12'($urandom_range(12, 1));
            write_expected(len);
            repeat ($urandom_range(6, 3))
            begin
                r = $urandom_range(9, 0);
                kind = (r <= 4) ? FR_CLEAN :
                       (r == 5) ? FR_DIRTY_SPARE :
                       (r == 6) ? FR_OVERRUN :
                       (r == 7) ? FR_TRUNCATED :
                       (r == 8) ? FR_BAD_CHAR : FR_NOISE;
                send_frame(kind, (cur_expected == 0) ? $urandom_range(3, 1) : cur_expected);
            end
        end
    endtask

    initial
    begin
        sb            = new(MAX_BYTES);
        cycles        = 0;
        live_chars    = 0;
        cur_expected  = EXP_RESET;
        send_idle_pct = 19;
        recv_idle_pct = 66;
        rst_n     <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tlast   <= 1'b0;
        m_tready  <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Short frame against the reset length: fails the count check
        send_text("AB");
        wait_idle();
        write_expected(12'd1);
        send_text("74");      // all-ones byte, clean
        send_text("AA");      // zero byte, clean
        send_text("77");      // nonzero spare bits
        send_text("AAA");     // five or more bits left over
        send_text("AAAA");    // one byte too many
        send_char(8'h00, 1'b0);
        send_char(CH_A, 1'b1);
        send_char(8'hFF, 1'b1);
        send_text("Z[");      // alphabet edge, then just past it
        send_text("A@");
        send_text("1");
        wait_idle();
        write_expected(12'd0);
        send_text("AA");      // first completed byte already too many
        send_text("A");

        run_phase(19, 66, 200);
        run_phase(66, 19, 200);
        run_phase(0, 0, 200);

        wait_idle();
        repeat (5) @(posedge clk);

        if (sb.decoded_due.size() != 0)
        begin
            $display("%0d expected results never arrived", sb.decoded_due.size());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

[filelist.f]
design/b32dec_pkg.sv
design/base32_strict_fixed_length_decoder_top.sv
sim/tb_top.sv
